// File: rtl/core/llds_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// llds_pkg: shared types and widths for the least-loaded dispatch unit
// Field widths, the search token that runs along the server chain and the
// control group that the dispatcher broadcasts to every server cell.
// ----------------------------------------------------------------------------
package llds_pkg;

  localparam int TIME_W = 32;
  localparam int WAIT_W = 48;
  localparam int PROC_W = 16;
  localparam int CNT_W  = 4;   // server count register and fill count
  localparam int SEL_W  = 4;   // chosen server is always below the count
  localparam int OIDX_W = 3;   // server index as reported on the result port

  // Running minimum carried from cell to cell
  typedef struct packed {
    logic              valid;
    logic [TIME_W-1:0] min_time;
    logic [SEL_W-1:0]  min_idx;
  } token_t;

  // Broadcast from the dispatcher to all cells
  typedef struct packed {
    logic              clear;
    logic              wr_en;
    logic [SEL_W-1:0]  wr_idx;
    logic [TIME_W-1:0] wr_time;
  } cell_ctl_t;

endpackage

// File: rtl/core/llds_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// llds_cell: one server of the dispatch chain
// Holds the time at which its server becomes free, folds itself into the
// passing search token and takes the new free time when it is chosen.
// ----------------------------------------------------------------------------
module llds_cell #(
  parameter int IDX = 0
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                active,
  input  llds_pkg::cell_ctl_t ctl,
  input  llds_pkg::token_t    tok_i,
  output llds_pkg::token_t    tok_o
);
  import llds_pkg::*;

  localparam logic [SEL_W-1:0] MY_IDX = SEL_W'(IDX);

  logic [TIME_W-1:0] free_r, free_nxt;
  token_t            tok_r, tok_nxt;
  logic              take;

  // Replace the running minimum only on a strictly earlier time (low index wins ties)
  assign take = active && tok_i.valid && (free_r < tok_i.min_time);

  always_comb begin
    tok_nxt = tok_i;
    if (take) begin
      tok_nxt.min_time = free_r;
      tok_nxt.min_idx  = MY_IDX;
    end
  end

  // Clear on batch start, load the finish time when this server is chosen
  always_comb begin
    free_nxt = free_r;
    if (ctl.clear) begin
      free_nxt = '0;
    end else if (ctl.wr_en && active && (ctl.wr_idx == MY_IDX)) begin
      free_nxt = ctl.wr_time;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      free_r      <= '0;
      tok_r.valid <= 1'b0;
    end else begin
      free_r <= free_nxt;
      tok_r  <= tok_nxt;
    end
  end

  assign tok_o = tok_r;

endmodule

// File: rtl/core/least_loaded_dispatch_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// least_loaded_dispatch_unit: greedy dispatch onto the earliest-free server
// Sends each job to a server, reports start and finish times, the running
// sum of start times and the latest finish time of the batch.
// ----------------------------------------------------------------------------
// A user should know: one request is taken at a time. While the opening jobs
// of a batch fill servers 0, 1, 2 and so on, the dispatcher goes from decide
// straight to finish. Once all active servers have a job, a search token
// walks the full chain of MAX_SERVERS server cells, one cell per cycle, and
// the dispatcher waits in search until the token leaves the chain. Finish
// holds while the output register is full and stalled. The result sits in an
// output register; the next request is taken as soon as the dispatcher is
// back in idle. Server count writes take effect at once and should be made
// between requests; counts of zero act as one and counts above MAX_SERVERS
// act as MAX_SERVERS.
// ----------------------------------------------------------------------------
module least_loaded_dispatch_unit #(
  parameter int MAX_SERVERS = 8
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // configuration
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [llds_pkg::CNT_W-1:0]    cfg_data,
  // job requests
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_batch_start,
  input  logic [llds_pkg::PROC_W-1:0]   in_proc_time,
  // results
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [llds_pkg::OIDX_W-1:0]   out_server_index,
  output logic [llds_pkg::TIME_W-1:0]   out_start_time,
  output logic [llds_pkg::TIME_W-1:0]   out_finish_time,
  output logic [llds_pkg::WAIT_W-1:0]   out_total_wait,
  output logic [llds_pkg::TIME_W-1:0]   out_close_time
);
  import llds_pkg::*;

  localparam logic [CNT_W-1:0] MAX_K =
    CNT_W'((MAX_SERVERS > 15) ? 15 : MAX_SERVERS);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_SEARCH,
    ST_FINISH
  } state_t;

  state_t             state_r, state_nxt;
  logic [CNT_W-1:0]   num_r, num_nxt;
  logic [CNT_W-1:0]   fill_r, fill_nxt;
  logic [WAIT_W-1:0]  wait_r, wait_nxt;
  logic [TIME_W-1:0]  late_r, late_nxt;
  logic [PROC_W-1:0]  proc_r, proc_nxt;
  logic [SEL_W-1:0]   sel_r, sel_nxt;
  logic [TIME_W-1:0]  start_r, start_nxt;

  logic               ov_r, ov_nxt;
  logic [OIDX_W-1:0]  o_idx_r, o_idx_nxt;
  logic [TIME_W-1:0]  o_start_r, o_start_nxt;
  logic [TIME_W-1:0]  o_fin_r, o_fin_nxt;
  logic [WAIT_W-1:0]  o_wait_r, o_wait_nxt;
  logic [TIME_W-1:0]  o_close_r, o_close_nxt;

  logic [CNT_W-1:0]   k;
  logic               accept;
  logic               can_load;
  logic [TIME_W:0]    fin_sum;
  logic [TIME_W-1:0]  fin;
  logic [WAIT_W:0]    wait_sum;
  logic [WAIT_W-1:0]  wait_sat;
  logic [TIME_W-1:0]  late_new;

  logic [MAX_SERVERS-1:0] act;
  token_t                 chain [MAX_SERVERS+1];
  cell_ctl_t              ctl;

  // Clamp the configured server count to 1..MAX_SERVERS
  always_comb begin
    if (num_r == '0) begin
      k = CNT_W'(1);
    end else if (num_r > MAX_K) begin
      k = MAX_K;
    end else begin
      k = num_r;
    end
  end

  assign cfg_ready = 1'b1;
  assign in_stall  = (state_r != ST_IDLE);
  assign accept    = in_valid && !in_stall;
  assign can_load  = !ov_r || !out_stall;

  // Saturating finish time and wait sum
  assign fin_sum  = {1'b0, start_r} + {{(TIME_W + 1 - PROC_W){1'b0}}, proc_r};
  assign fin      = fin_sum[TIME_W] ? '1 : fin_sum[TIME_W-1:0];
  assign wait_sum = {1'b0, wait_r} + {{(WAIT_W + 1 - TIME_W){1'b0}}, start_r};
  assign wait_sat = wait_sum[WAIT_W] ? '1 : wait_sum[WAIT_W-1:0];
  assign late_new = (fin > late_r) ? fin : late_r;

  // Broadcast clear on a batch start and write back the chosen server
  always_comb begin
    ctl.clear   = accept && in_batch_start;
    ctl.wr_en   = (state_r == ST_FINISH) && can_load;
    ctl.wr_idx  = sel_r;
    ctl.wr_time = fin;
  end

  // Seed the search token at the head of the chain
  always_comb begin
    chain[0].valid    = (state_r == ST_DECIDE) && (fill_r >= k);
    chain[0].min_time = '1;
    chain[0].min_idx  = '0;
  end

  for (genvar i = 0; i < MAX_SERVERS; i++) begin : g_cell
    assign act[i] = (7'(i) < {3'b000, k});

    llds_cell #(
      .IDX (i)
    ) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .active (act[i]),
      .ctl    (ctl),
      .tok_i  (chain[i]),
      .tok_o  (chain[i+1])
    );
  end

  // Dispatcher next state
  always_comb begin
    state_nxt   = state_r;
    num_nxt     = num_r;
    fill_nxt    = fill_r;
    wait_nxt    = wait_r;
    late_nxt    = late_r;
    proc_nxt    = proc_r;
    sel_nxt     = sel_r;
    start_nxt   = start_r;
    ov_nxt      = ov_r && out_stall;
    o_idx_nxt   = o_idx_r;
    o_start_nxt = o_start_r;
    o_fin_nxt   = o_fin_r;
    o_wait_nxt  = o_wait_r;
    o_close_nxt = o_close_r;

    if (cfg_valid && cfg_ready) begin
      num_nxt = cfg_data;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          proc_nxt  = in_proc_time;
          state_nxt = ST_DECIDE;
          if (in_batch_start) begin
            fill_nxt = '0;
            wait_nxt = '0;
            late_nxt = '0;
          end
        end
      end
      ST_DECIDE: begin
        if (fill_r < k) begin
          // opening phase: next unused server, free at time zero
          sel_nxt   = fill_r;
          start_nxt = '0;
          fill_nxt  = fill_r + CNT_W'(1);
          state_nxt = ST_FINISH;
        end else begin
          state_nxt = ST_SEARCH;
        end
      end
      ST_SEARCH: begin
        if (chain[MAX_SERVERS].valid) begin
          sel_nxt   = chain[MAX_SERVERS].min_idx;
          start_nxt = chain[MAX_SERVERS].min_time;
          state_nxt = ST_FINISH;
        end
      end
      ST_FINISH: begin
        // hold until the output register is free, then commit
        if (can_load) begin
          wait_nxt    = wait_sat;
          late_nxt    = late_new;
          ov_nxt      = 1'b1;
          o_idx_nxt   = sel_r[OIDX_W-1:0];
          o_start_nxt = start_r;
          o_fin_nxt   = fin;
          o_wait_nxt  = wait_sat;
          o_close_nxt = late_new;
          state_nxt   = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      num_r   <= CNT_W'(8);
      fill_r  <= '0;
      wait_r  <= '0;
      late_r  <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      num_r   <= num_nxt;
      fill_r  <= fill_nxt;
      wait_r  <= wait_nxt;
      late_r  <= late_nxt;
      ov_r    <= ov_nxt;
    end
    proc_r    <= proc_nxt;
    sel_r     <= sel_nxt;
    start_r   <= start_nxt;
    o_idx_r   <= o_idx_nxt;
    o_start_r <= o_start_nxt;
    o_fin_r   <= o_fin_nxt;
    o_wait_r  <= o_wait_nxt;
    o_close_r <= o_close_nxt;
  end

  assign out_valid        = ov_r;
  assign out_server_index = o_idx_r;
  assign out_start_time   = o_start_r;
  assign out_finish_time  = o_fin_r;
  assign out_total_wait   = o_wait_r;
  assign out_close_time   = o_close_r;

`ifndef SYNTH
  // A token leaves the chain only while the dispatcher waits for it
  a_token_in_search: assert property (@(posedge clk) disable iff (!rst_n)
    chain[MAX_SERVERS].valid |-> (state_r == ST_SEARCH))
    else $error("search token left the chain outside of a search");

  // Opening-phase fill never runs past the largest usable count
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= MAX_K)
    else $error("fill count beyond server count");

  // A new result appears only as the dispatcher commits a job
  a_result_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
    (ov_r && !out_stall) ##1 ov_r |-> ($past(state_r) == ST_FINISH))
    else $error("result loaded outside of commit");

  // Finish never precedes start and the close time covers it
  a_time_order: assert property (@(posedge clk) disable iff (!rst_n)
    ov_r |-> (o_fin_r >= o_start_r) && (o_close_r >= o_fin_r))
    else $error("result times out of order");
`endif

endmodule

// File: tb/llds_dispatch_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// llds_dispatch_checker: schedule predictor and result checker
// Watches the configuration, request and result channels of the dispatch
// unit. It keeps its own copy of the server free times and batch totals,
// predicts the result of every accepted request and compares each accepted
// result field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module llds_dispatch_checker #(
  parameter int MAX_SERVERS = 8
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_valid,
  input  logic                        cfg_ready,
  input  logic [llds_pkg::CNT_W-1:0]  cfg_data,
  input  logic                        in_valid,
  input  logic                        in_stall,
  input  logic                        in_batch_start,
  input  logic [llds_pkg::PROC_W-1:0] in_proc_time,
  input  logic                        out_valid,
  input  logic                        out_stall,
  input  logic [llds_pkg::OIDX_W-1:0] out_server_index,
  input  logic [llds_pkg::TIME_W-1:0] out_start_time,
  input  logic [llds_pkg::TIME_W-1:0] out_finish_time,
  input  logic [llds_pkg::WAIT_W-1:0] out_total_wait,
  input  logic [llds_pkg::TIME_W-1:0] out_close_time,
  output int                          fail_count,
  output int                          pending
);
  import llds_pkg::*;

  localparam logic [CNT_W-1:0] COUNT_AT_RESET = CNT_W'(8);

  typedef struct packed {
    logic [OIDX_W-1:0] server_index;
    logic [TIME_W-1:0] start_time;
    logic [TIME_W-1:0] finish_time;
    logic [WAIT_W-1:0] total_wait;
    logic [TIME_W-1:0] close_time;
  } dispatch_t;

  dispatch_t         expected_dispatch[$];
  logic [TIME_W-1:0] free_at [MAX_SERVERS];
  logic [CNT_W-1:0]  servers_filled;
  logic [WAIT_W-1:0] wait_total;
  logic [TIME_W-1:0] latest_done;
  logic [CNT_W-1:0]  server_count;

  initial begin
    fail_count = 0;
    pending    = 0;
  end

  // Drop all server times and batch totals
  function automatic void clear_schedule();
    for (int i = 0; i < MAX_SERVERS; i++) free_at[i] = '0;
    servers_filled = '0;
    wait_total     = '0;
    latest_done    = '0;
  endfunction

  // Place one job and advance the schedule
  function automatic dispatch_t predict_dispatch(input logic clear,
                                                 input logic [PROC_W-1:0] proc);
    int                active;
    int                pick;
    logic [TIME_W:0]   finish_sum;
    logic [WAIT_W:0]   wait_sum;
    dispatch_t         res;
    if (clear) clear_schedule();
    active = (server_count == 0) ? 1 :
             (server_count > MAX_SERVERS) ? MAX_SERVERS : int'(server_count);
    // Opening phase fills servers in order, then pick the earliest free
    if (int'(servers_filled) < active) begin
      pick = int'(servers_filled);
      servers_filled++;
    end else begin
      pick = 0;
      for (int i = 1; i < active; i++)
        if (free_at[i] < free_at[pick]) pick = i;
    end
    res.server_index = OIDX_W'(pick);
    res.start_time   = free_at[pick];
    finish_sum       = {1'b0, free_at[pick]} + (TIME_W+1)'(proc);
    res.finish_time  = finish_sum[TIME_W] ? '1 : finish_sum[TIME_W-1:0];
    free_at[pick]    = res.finish_time;
    wait_sum         = {1'b0, wait_total} + (WAIT_W+1)'(res.start_time);
    wait_total       = wait_sum[WAIT_W] ? '1 : wait_sum[WAIT_W-1:0];
    if (res.finish_time > latest_done) latest_done = res.finish_time;
    res.total_wait   = wait_total;
    res.close_time   = latest_done;
    return res;
  endfunction

  function automatic void check_field(input string field, input logic [63:0] want,
                                      input logic [63:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", field, want, got);
      fail_count++;
    end
  endfunction

  // Track every handshake at the rising edge
  always @(posedge clk) begin
    dispatch_t want;
    if (!rst_n) begin
      clear_schedule();
      server_count = COUNT_AT_RESET;
      expected_dispatch.delete();
    end else begin
      if (cfg_valid && cfg_ready) server_count = cfg_data;
      // Retire the oldest prediction against the accepted result
      if (out_valid && !out_stall) begin
        if (expected_dispatch.size() == 0) begin
          $error("result with no request pending: server_index %0d, start_time %0d",
                 out_server_index, out_start_time);
          fail_count++;
        end else begin
          want = expected_dispatch.pop_front();
          check_field("server_index", want.server_index, out_server_index);
          check_field("start_time",   want.start_time,   out_start_time);
          check_field("finish_time",  want.finish_time,  out_finish_time);
          check_field("total_wait",   want.total_wait,   out_total_wait);
          check_field("close_time",   want.close_time,   out_close_time);
        end
      end
      if (in_valid && !in_stall)
        expected_dispatch.push_back(predict_dispatch(in_batch_start, in_proc_time));
    end
    pending = expected_dispatch.size();
  end

endmodule

// File: tb/tb_least_loaded_dispatch_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_least_loaded_dispatch_unit: regression for the least-loaded dispatcher
// Drives directed jobs, random batches under random server counts with
// random sender gaps and receiver stalls, a long receiver hold-off, and a
// single-server run of the longest jobs. The checker beside the block
// predicts and compares.
// ----------------------------------------------------------------------------
module tb_least_loaded_dispatch_unit;
  import llds_pkg::*;

  localparam int MAX_SERVERS  = 8;
  localparam int RANDOM_JOBS  = 800;
  localparam int QUIET_JOBS   = 150;           // tail of the random part with no idling
  localparam int HOLD_CYCLES  = 64;
  localparam int LONG_JOBS    = 20;            // one-server run of the longest jobs
  localparam int SETTLE_LIMIT = 2 * MAX_SERVERS + 8;

  logic              clk;
  logic              rst_n;
  logic              cfg_valid;
  logic              cfg_ready;
  logic [CNT_W-1:0]  cfg_data;
  logic              in_valid;
  logic              in_stall;
  logic              in_batch_start;
  logic [PROC_W-1:0] in_proc_time;
  logic              out_valid;
  logic              out_stall;
  logic [OIDX_W-1:0] out_server_index;
  logic [TIME_W-1:0] out_start_time;
  logic [TIME_W-1:0] out_finish_time;
  logic [WAIT_W-1:0] out_total_wait;
  logic [TIME_W-1:0] out_close_time;

  int fail_count;
  int pending;
  int jobs_sent;
  bit sender_idle;
  bit receiver_idle;
  bit hold_request;

  least_loaded_dispatch_unit #(.MAX_SERVERS(MAX_SERVERS)) uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_batch_start   (in_batch_start),
    .in_proc_time     (in_proc_time),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_server_index (out_server_index),
    .out_start_time   (out_start_time),
    .out_finish_time  (out_finish_time),
    .out_total_wait   (out_total_wait),
    .out_close_time   (out_close_time)
  );

  llds_dispatch_checker #(.MAX_SERVERS(MAX_SERVERS)) dispatch_chk (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_batch_start   (in_batch_start),
    .in_proc_time     (in_proc_time),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_server_index (out_server_index),
    .out_start_time   (out_start_time),
    .out_finish_time  (out_finish_time),
    .out_total_wait   (out_total_wait),
    .out_close_time   (out_close_time),
    .fail_count       (fail_count),
    .pending          (pending)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Hard stop well beyond the slowest legal run
  initial begin
    #1_000_000;
    $display("least_loaded_dispatch_unit regression: fail");
    $finish;
  end

  // Result side: random stall bursts, plus one long hold-off on request
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        out_stall <= 1'b0;
      end else if (receiver_idle && $urandom_range(0, 3) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 3)) @(negedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // Offer one job request and hold it until accepted; returns at a falling edge
  task automatic send_job(input logic batch, input logic [PROC_W-1:0] proc);
    if (sender_idle && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk);
    end
    in_valid       <= 1'b1;
    in_batch_start <= batch;
    in_proc_time   <= proc;
    do @(posedge clk); while (in_stall);
    jobs_sent++;
    @(negedge clk);
  endtask

  // Hold off new requests until every result has come back
  task automatic wait_idle();
    if (in_valid) in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  task automatic write_count(input logic [CNT_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Processing time drawn from one of several shapes
  function automatic logic [PROC_W-1:0] random_proc(input int shape);
    case (shape)
      0:       return PROC_W'($urandom_range(0, 7));
      1: begin
        case ($urandom_range(0, 2))
          0:       return '0;
          1:       return '1;
          default: return PROC_W'($urandom);
        endcase
      end
      2:       return PROC_W'($urandom_range(60000, 65535));
      default: return PROC_W'($urandom);
    endcase
  endfunction

  initial begin
    int random_start;
    int seg;
    int seg_len;
    int shape;
    cfg_valid      = 1'b0;
    cfg_data       = '0;
    in_valid       = 1'b0;
    in_batch_start = 1'b0;
    in_proc_time   = '0;
    sender_idle    = 1'b0;
    receiver_idle  = 1'b0;
    hold_request   = 1'b0;
    jobs_sent      = 0;
    rst_n          = 1'b0;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Default count: fill all servers, then search with ties at time 0
    send_job(1'b1, 16'd0);
    send_job(1'b0, 16'hFFFF);
    send_job(1'b0, 16'd1);
    send_job(1'b0, 16'h8000);
    send_job(1'b0, 16'h7FFF);
    send_job(1'b0, 16'd0);
    send_job(1'b0, 16'd0);
    send_job(1'b0, 16'd2);
    send_job(1'b0, 16'd3);
    send_job(1'b0, 16'd5);

    // Count of zero acts as one server
    wait_idle();
    write_count(CNT_W'(0));
    send_job(1'b1, 16'd7);
    send_job(1'b0, 16'd9);
    send_job(1'b0, 16'd0);

    // Count above the maximum acts as the maximum; unused servers start at 0
    wait_idle();
    write_count('1);
    send_job(1'b0, 16'd4);
    send_job(1'b0, 16'd4);

    // Count changed in the middle of a batch
    wait_idle();
    write_count(CNT_W'(2));
    send_job(1'b1, 16'd10);
    send_job(1'b0, 16'd20);
    send_job(1'b0, 16'd5);
    send_job(1'b0, 16'd5);
    wait_idle();
    write_count(CNT_W'(5));
    send_job(1'b0, 16'd1);
    send_job(1'b0, 16'd1);
    send_job(1'b0, 16'd1);
    send_job(1'b0, 16'd1);

    // Random batches under random counts; quiet tail at the end
    random_start = jobs_sent;
    seg = 0;
    while (jobs_sent - random_start < RANDOM_JOBS) begin
      wait_idle();
      if (jobs_sent - random_start >= RANDOM_JOBS - QUIET_JOBS) begin
        sender_idle   = 1'b0;
        receiver_idle = 1'b0;
      end else begin
        sender_idle   = ($urandom_range(0, 3) != 0);
        receiver_idle = ($urandom_range(0, 3) != 0);
      end
      if (seg == 0 || $urandom_range(0, 2) == 0) write_count(CNT_W'($urandom_range(0, 15)));
      seg_len = $urandom_range(1, 40);
      if (seg == 4) begin
        hold_request = 1'b1;
        seg_len      = 30;
      end
      shape = $urandom_range(0, 3);
      for (int j = 0; j < seg_len; j++)
        send_job((j == 0) ? ($urandom_range(0, 3) != 0) : ($urandom_range(0, 19) == 0),
                 random_proc(shape));
      seg++;
    end

    // One server, longest jobs back to back
    wait_idle();
    sender_idle   = 1'b0;
    receiver_idle = 1'b0;
    write_count(CNT_W'(1));
    send_job(1'b1, '1);
    for (int j = 1; j < LONG_JOBS; j++) send_job(1'b0, '1);
    // New batch straight out of the long run
    send_job(1'b1, 16'd0);
    send_job(1'b0, 16'd3);

    wait_idle();
    repeat (SETTLE_LIMIT) @(negedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("least_loaded_dispatch_unit regression: pass");
    end else begin
      $display("least_loaded_dispatch_unit regression: fail");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/core/llds_pkg.sv
rtl/core/llds_cell.sv
rtl/core/least_loaded_dispatch_unit.sv
tb/llds_dispatch_checker.sv
tb/tb_least_loaded_dispatch_unit.sv
